/* rtl/ssrc_pkg.sv */
// Shared types, command codes and CRC-8 helpers for the serial sensor read block.
// No dependencies.
`timescale 1ns / 1ps

package ssrc_pkg;

  typedef logic [1:0]  cmd_t;
  typedef logic [15:0] word_t;
  typedef logic [7:0]  crc_t;

  localparam cmd_t CMD_TICK   = 2'd0;
  localparam cmd_t CMD_START  = 2'd1;
  localparam cmd_t CMD_UPDATE = 2'd2;

  localparam crc_t CRC_POLY = 8'h1D;
  localparam crc_t CRC_SEED = 8'hFF;

  localparam int WORD_BITS = 16;

  // One bit of CRC-8, MSB-first feed.
  function automatic crc_t crc_bit(input crc_t crc, input logic b);
    logic fb;
    crc_t sh;
    fb = crc[7] ^ b;
    sh = {crc[6:0], 1'b0};
    return fb ? (sh ^ CRC_POLY) : sh;
  endfunction

endpackage

/* rtl/spi_sensor_read_with_crc8_top.sv */
// Serial sensor read master: command send, word receive, bit-serial CRC-8 check.
// Depends on ssrc_pkg.
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in       sink       in_valid/in_ready    command, command_word, miso
// out      source     out_valid/out_ready  select_n, clock_pulse, mosi, word_valid,
//                                          word_value, done_res, crc_ok
// Each accepted item is one serial tick and yields exactly one result item.
// The state step is combinational; the result sits in an output register, loaded when the item is accepted.
// in_ready is high whenever the output register is empty or being drained, so an
// item can enter every cycle while out_ready stays high.
// rst is synchronous; it clears the phase, counters, shift registers and output valid and loads the CRC seed.
// A stall on out holds the result and blocks further input until it is taken.

module spi_sensor_read_with_crc8_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssrc_pkg::cmd_t      command,
  input  ssrc_pkg::word_t     command_word,
  input  logic                miso,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                select_n,
  output logic                clock_pulse,
  output logic                mosi,
  output logic                word_valid,
  output ssrc_pkg::word_t     word_value,
  output logic                done_res,
  output logic                crc_ok
);
  import ssrc_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SEND = 2'd1;
  localparam logic [1:0] PH_RECV = 2'd2;

  logic [1:0] phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [4:0] word_count, word_count_next;
  logic [3:0] words_wanted, words_wanted_next;
  word_t      command_shift, command_shift_next;
  word_t      receive_shift, receive_shift_next;
  crc_t       crc_register, crc_register_next;

  logic  sel_c, clk_c, mo_c, wv_c, done_c, ok_c;
  word_t wval_c, word_c;
  logic  accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    word_count_next    = word_count;
    words_wanted_next  = words_wanted;
    command_shift_next = command_shift;
    receive_shift_next = receive_shift;
    crc_register_next  = crc_register;
    sel_c  = 1'b1;
    clk_c  = 1'b0;
    mo_c   = 1'b1;
    wv_c   = 1'b0;
    wval_c = '0;
    done_c = 1'b0;
    ok_c   = 1'b0;
    word_c = {receive_shift[WORD_BITS-2:0], miso};
    unique case (phase)
      PH_SEND: begin
        sel_c = 1'b0;
        clk_c = 1'b1;
        mo_c  = command_shift[WORD_BITS-1];
        crc_register_next  = crc_bit(crc_register, command_shift[WORD_BITS-1]);
        command_shift_next = {command_shift[WORD_BITS-2:0], 1'b0};
        if (bit_count == 4'd15) begin
          bit_count_next     = '0;
          word_count_next    = '0;
          receive_shift_next = '0;
          phase_next         = PH_RECV;
        end else begin
          bit_count_next = bit_count + 4'd1;
        end
      end
      PH_RECV: begin
        sel_c = 1'b0;
        clk_c = 1'b1;
        if (word_count == 5'd0) begin
          crc_register_next = crc_bit(crc_register, (words_wanted != 4'd0) && miso);
        end
        receive_shift_next = word_c;
        if (bit_count == 4'd15) begin
          bit_count_next     = '0;
          receive_shift_next = '0;
          if (word_count < {1'b0, words_wanted}) begin
            wv_c            = 1'b1;
            wval_c          = word_c;
            word_count_next = word_count + 5'd1;
          end else begin
            done_c     = 1'b1;
            ok_c       = (word_c[7:0] == ~crc_register_next);
            phase_next = PH_IDLE;
          end
        end else begin
          bit_count_next = bit_count + 4'd1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (command == CMD_START) begin
          sel_c              = 1'b0;
          command_shift_next = command_word;
          words_wanted_next  = command_word[3:0];
          bit_count_next     = '0;
          word_count_next    = '0;
          receive_shift_next = '0;
          crc_register_next  = CRC_SEED;
          phase_next         = PH_SEND;
        end else if (command == CMD_UPDATE) begin
          sel_c = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_count     <= '0;
      word_count    <= '0;
      words_wanted  <= '0;
      command_shift <= '0;
      receive_shift <= '0;
      crc_register  <= CRC_SEED;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        bit_count     <= bit_count_next;
        word_count    <= word_count_next;
        words_wanted  <= words_wanted_next;
        command_shift <= command_shift_next;
        receive_shift <= receive_shift_next;
        crc_register  <= crc_register_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      select_n    <= sel_c;
      clock_pulse <= clk_c;
      mosi        <= mo_c;
      word_valid  <= wv_c;
      word_value  <= wval_c;
      done_res    <= done_c;
      crc_ok      <= ok_c;
    end
  end

  a_done_not_word: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(done_res && word_valid))
    else $error("done and word_valid together");

  a_ok_needs_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && crc_ok) |-> done_res)
    else $error("crc_ok without done");

  a_clock_in_select: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clock_pulse) |-> !select_n)
    else $error("clock pulse while deselected");

  a_start_sends: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_IDLE && command == CMD_START) |=> phase == PH_SEND)
    else $error("start did not enter send");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && done_c) |=> phase == PH_IDLE)
    else $error("done did not return to idle");

endmodule

/* tb/tb_spi_sensor_read_with_crc8_top.sv */
// Self-checking testbench for the serial sensor read master with CRC-8 check.
// Drives queued tick items, predicts every result item and compares them in order.
// Depends on ssrc_pkg and spi_sensor_read_with_crc8_top.
`timescale 1ns / 1ps

module tb_spi_sensor_read_with_crc8_top;
  import ssrc_pkg::*;

  localparam cmd_t CMD_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int TARGET_ITEMS = 1250;

  typedef enum logic [1:0] {PH_IDLE, PH_SEND, PH_RECV} phase_e;

  typedef struct {
    cmd_t  cmd;
    word_t cw;
    logic  miso;
    int    pause;
  } tick_t;

  typedef struct {
    logic  sel_n;
    logic  clk_p;
    logic  mosi;
    logic  wv;
    word_t wval;
    logic  done;
    logic  ok;
  } result_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  cmd_t  command = CMD_TICK;
  word_t command_word = '0;
  logic  miso = 1'b0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  logic  select_n;
  logic  clock_pulse;
  logic  mosi;
  logic  word_valid;
  word_t word_value;
  logic  done_res;
  logic  crc_ok;

  tick_t   tick_queue[$];
  result_t expected_ticks[$];
  tick_t   next_tick;
  result_t want;
  int      err_count = 0;
  int      gap_left = 0;
  int      stall_left = 0;
  int      calm_left = 0;
  int      idle_cycles = 0;
  int      roll;

  // predictor state
  phase_e     ph = PH_IDLE;
  logic [3:0] bit_idx = '0;
  logic [4:0] words_done = '0;
  logic [3:0] words_req = '0;
  word_t      tx_shift = '0;
  word_t      rx_shift = '0;
  crc_t       crc_acc = CRC_SEED;

  spi_sensor_read_with_crc8_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .command_word(command_word), .miso(miso),
    .out_valid(out_valid), .out_ready(out_ready),
    .select_n(select_n), .clock_pulse(clock_pulse), .mosi(mosi),
    .word_valid(word_valid), .word_value(word_value),
    .done_res(done_res), .crc_ok(crc_ok)
  );

  always #6 clk = ~clk;

  function automatic crc_t crc8_shift(input crc_t c, input logic b);
    return {c[6:0], 1'b0} ^ ({8{c[7] ^ b}} & CRC_POLY);
  endfunction

  function automatic result_t step_sensor_master(input cmd_t cmd, input word_t cw,
                                                 input logic sdi);
    result_t r;
    word_t   word;
    r = '{sel_n: 1'b1, clk_p: 1'b0, mosi: 1'b1, wv: 1'b0, wval: '0, done: 1'b0, ok: 1'b0};
    case (ph)
      PH_SEND: begin
        r.sel_n = 1'b0;
        r.clk_p = 1'b1;
        r.mosi = tx_shift[15];
        crc_acc = crc8_shift(crc_acc, tx_shift[15]);
        tx_shift = {tx_shift[14:0], 1'b0};
        if (bit_idx == 4'd15) begin
          bit_idx = '0;
          words_done = '0;
          rx_shift = '0;
          ph = PH_RECV;
        end else begin
          bit_idx = bit_idx + 4'd1;
        end
      end
      PH_RECV: begin
        r.sel_n = 1'b0;
        r.clk_p = 1'b1;
        // only the first data word (or zeros when none) enters the CRC
        if (words_done == 0) crc_acc = crc8_shift(crc_acc, (words_req != 0) ? sdi : 1'b0);
        word = {rx_shift[14:0], sdi};
        rx_shift = word;
        if (bit_idx == 4'd15) begin
          bit_idx = '0;
          if (words_done < {1'b0, words_req}) begin
            r.wv = 1'b1;
            r.wval = word;
            words_done = words_done + 5'd1;
          end else begin
            r.done = 1'b1;
            r.ok = (word[7:0] == ~crc_acc);
            ph = PH_IDLE;
          end
          rx_shift = '0;
        end else begin
          bit_idx = bit_idx + 4'd1;
        end
      end
      default: begin
        ph = PH_IDLE;
        if (cmd == CMD_START) begin
          r.sel_n = 1'b0;
          tx_shift = cw;
          words_req = cw[3:0];
          bit_idx = '0;
          words_done = '0;
          rx_shift = '0;
          crc_acc = CRC_SEED;
          ph = PH_SEND;
        end else if (cmd == CMD_UPDATE) begin
          r.sel_n = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      err_count++;
    end
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic push_tick(input cmd_t c, input word_t w, input logic m, input bit calm);
    tick_t t;
    t.cmd = c;
    t.cw = w;
    t.miso = m;
    t.pause = calm ? 0 : pick_pause();
    tick_queue.push_back(t);
  endtask

  // commands sent while busy must be ignored, so any code goes
  task automatic push_busy_tick(input logic m, input bit calm);
    push_tick(cmd_t'($urandom_range(0, 3)), word_t'($urandom_range(0, 65535)), m, calm);
  endtask

  task automatic queue_read(input word_t cw, input bit good_crc, input bit calm);
    word_t words[$];
    word_t first;
    word_t safety;
    crc_t  crc;
    int    n;
    n = cw[3:0];
    crc = CRC_SEED;
    for (int i = 15; i >= 0; i--) crc = crc8_shift(crc, cw[i]);
    for (int k = 0; k < n; k++) words.push_back(word_t'($urandom_range(0, 65535)));
    first = (n > 0) ? words[0] : '0;
    for (int i = 15; i >= 0; i--) crc = crc8_shift(crc, first[i]);
    safety = word_t'($urandom_range(0, 65535));
    if (good_crc) safety[7:0] = ~crc;
    words.push_back(safety);
    push_tick(CMD_START, cw, 1'($urandom_range(0, 1)), calm);
    repeat (16) push_busy_tick(1'($urandom_range(0, 1)), calm);
    foreach (words[k])
      for (int i = 15; i >= 0; i--) push_busy_tick(words[k][i], calm);
  endtask

  task automatic queue_noise(input int count, input bit calm);
    cmd_t c;
    repeat (count) begin
      roll = $urandom_range(0, 2);
      c = (roll == 0) ? CMD_TICK : (roll == 1) ? CMD_UPDATE : CMD_SPARE;
      push_tick(c, word_t'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), calm);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (tick_queue.size() > 0) begin
        next_tick = tick_queue.pop_front();
        in_valid <= 1'b1;
        command <= next_tick.cmd;
        command_word <= next_tick.cw;
        miso <= next_tick.miso;
        gap_left <= next_tick.pause;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      calm_left <= 0;
    end else if (calm_left > 0) begin
      out_ready <= 1'b1;
      calm_left <= calm_left - 1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        out_ready <= 1'b1;
        calm_left <= $urandom_range(40, 150);
      end else if (roll < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left <= pick_pause();
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      ph <= PH_IDLE;
      bit_idx <= '0;
      words_done <= '0;
      words_req <= '0;
      tx_shift <= '0;
      rx_shift <= '0;
      crc_acc <= CRC_SEED;
    end else begin
      if (in_valid && in_ready)
        expected_ticks.push_back(step_sensor_master(command, command_word, miso));
      if (out_valid && out_ready) begin
        if (expected_ticks.size() == 0) begin
          $error("result item with no item pending");
          err_count++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("select_n", want.sel_n, select_n);
          check_field("clock_pulse", want.clk_p, clock_pulse);
          check_field("mosi", want.mosi, mosi);
          check_field("word_valid", want.wv, word_valid);
          check_field("word_value", want.wval, word_value);
          check_field("done_res", want.done, done_res);
          check_field("crc_ok", want.ok, crc_ok);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int n;
    bit calm;
    // directed: idle commands, extremes of the word count and CRC match/mismatch
    push_tick(CMD_TICK, 16'h0000, 1'b0, 1'b0);
    push_tick(CMD_UPDATE, 16'hFFFF, 1'b1, 1'b0);
    push_tick(CMD_UPDATE, 16'h0000, 1'b0, 1'b1);
    push_tick(CMD_SPARE, 16'hA5A5, 1'b1, 1'b0);
    queue_read(16'h0000, 1'b1, 1'b1);
    queue_read(16'hFFF0, 1'b0, 1'b0);
    queue_read(16'h8001, 1'b1, 1'b0);
    queue_read(16'h7FF2, 1'b0, 1'b1);
    push_tick(CMD_UPDATE, 16'h5A5A, 1'b0, 1'b1);
    queue_read(16'hFFFF, 1'b1, 1'b0);
    queue_read(16'h1230, 1'b1, 1'b1);

    while (tick_queue.size() < TARGET_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 70) begin
        roll = $urandom_range(0, 99);
        n = (roll < 80) ? $urandom_range(0, 3) :
            (roll < 95) ? $urandom_range(4, 8) : $urandom_range(9, 15);
        queue_read({12'($urandom_range(0, 4095)), 4'(n)}, $urandom_range(0, 99) < 80, calm);
      end else begin
        queue_noise($urandom_range(1, 6), calm);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (tick_queue.size() != 0 || in_valid || expected_ticks.size() != 0);
    repeat (4) @(posedge clk);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ssrc_pkg.sv
rtl/spi_sensor_read_with_crc8_top.sv
tb/tb_spi_sensor_read_with_crc8_top.sv
